[design/mnpr_pkg.sv]
// Package for the MIDI note pairing recorder.
// Holds the payload structs, event codes and sizing constants; no dependencies.
`default_nettype none

package mnpr_pkg;

    // Capacity of the external record store and the width of the fill count.
    localparam int MAX_RECORDS = 65536;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int NOTES   = 128;
    localparam int NOTE_W  = $clog2(NOTES);
    localparam int INDEX_W = 16;
    localparam int TIME_W  = 32;

    // Event kinds, taken from status bits 6..4.
    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_CTRL     = 3'd3;
    localparam logic [2:0] KIND_PROGRAM  = 3'd4;

    // Controller numbers and the bank that selects the drum kit.
    localparam logic [6:0] CTRL_BANK_MSB = 7'h00;
    localparam logic [6:0] CTRL_BANK_LSB = 7'h20;
    localparam logic [6:0] DRUM_BANK_MSB = 7'h7f;
    localparam logic [6:0] DRUM_BANK_LSB = 7'h00;
    localparam logic [7:0] DRUM_SHIFT    = 8'd12;

    // Result actions.
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_LENGTH = 1'b1;

    // Commands.
    localparam logic CMD_EVENT       = 1'b0;
    localparam logic CMD_BEGIN_TRACK = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] event_time;
        logic [7:0]        status_byte;
        logic [6:0]        first_data;
        logic [6:0]        second_data;
    } t_in;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] record_index;
        logic [TIME_W-1:0]  record_time;
        logic [2:0]         event_kind;
        logic [7:0]         note_value;
        logic [6:0]         velocity_value;
        logic [TIME_W-1:0]  note_length;
        logic               overflow;
        logic               last;
    } t_out;

    // One entry of the active note table held in RAM.
    typedef struct packed {
        logic [INDEX_W-1:0] record;
        logic [TIME_W-1:0]  start;
    } t_open;

    // Results handed to the output queue together in one push.
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_push;

endpackage

`default_nettype wire

[design/mnpr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the active note table of the MIDI note recorder.
`default_nettype none

module mnpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/mnpr_out_fifo.sv]
// Two-entry output queue that takes up to two results per cycle.
// Depends on mnpr_pkg for the result struct and the push bundle.
`default_nettype none

module mnpr_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mnpr_pkg::t_push i_push,
    output logic [1:0]          o_space,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mnpr_pkg::t_out      o_out
);

    mnpr_pkg::t_out r_q0;
    mnpr_pkg::t_out r_q1;
    mnpr_pkg::t_out n_q0;
    mnpr_pkg::t_out n_q1;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic [1:0]     w_kept;
    logic           w_pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q0;
    assign o_space     = 2'd2 - r_cnt;
    assign w_pop       = o_out_valid && i_out_ready;

    // The producer never pushes more than the free space seen before a pop.
    always_comb begin
        w_kept = r_cnt - {1'b0, w_pop};
        n_q0   = w_pop ? r_q1 : r_q0;
        n_q1   = r_q1;
        if (i_push.count != 2'd0) begin
            if (w_kept == 2'd0) begin
                n_q0 = i_push.first;
                n_q1 = i_push.second;
            end else begin
                n_q1 = i_push.first;
            end
        end
        n_cnt = w_kept + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

`default_nettype wire

[design/midi_note_pairing_recorder.sv]
// Top level of the MIDI note pairing recorder.
// Depends on mnpr_pkg, mnpr_ram and mnpr_out_fifo.
//
// Usage: timed MIDI channel events enter on the input channel (i_in_valid,
// o_in_ready, i_in). Each event yields zero, one or two record commands on
// the output channel (o_out_valid, i_out_ready, o_out): append a record, or
// set the length of a record appended earlier. The last flag marks the
// final command caused by one event.
// An event is accepted in S_IDLE, which reads its active note entry from the
// note table RAM; S_EXEC then evaluates, updates it and queues the results.
// A new event is taken only once S_EXEC has finished with the current one.
// Results pass through a two-entry output queue, so an event is accepted
// while earlier results still wait. If the receiver stalls, evaluation
// holds until the queue has room for all results of the current event.
// After reset, and after a begin-track command, all notes are closed, the
// record count, bank selection and repeat filter are cleared. The table
// RAM itself needs no clearing since an entry is only used while its
// valid flag is set.
`default_nettype none

module midi_note_pairing_recorder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mnpr_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mnpr_pkg::t_out     o_out
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                              r_state;
    mnpr_pkg::t_in                       r_in;
    logic [mnpr_pkg::NOTES-1:0]          r_open_valid;
    logic [mnpr_pkg::CNT_W-1:0]          r_count;
    logic [mnpr_pkg::TIME_W-1:0]         r_last_time;
    logic [7:0]                          r_last_status;
    logic [6:0]                          r_last_first;
    logic [6:0]                          r_last_second;
    logic [6:0]                          r_bank_high;
    logic [6:0]                          r_bank_low;

    mnpr_pkg::t_open                     w_rd_entry;
    mnpr_pkg::t_open                     w_wr_entry;
    mnpr_pkg::t_push                     w_push;
    mnpr_pkg::t_out                      w_close;
    mnpr_pkg::t_out                      w_append;
    logic [1:0]                          w_space;
    logic                                w_accept;
    logic [2:0]                          w_kind;
    logic                                w_repeat;
    logic                                w_is_off;
    logic                                w_is_on;
    logic                                w_was_open;
    logic                                w_do_close;
    logic                                w_do_append;
    logic                                w_full;
    logic                                w_go;
    logic                                w_store;
    logic [mnpr_pkg::NOTE_W-1:0]         w_key;
    logic [7:0]                          w_note;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_key      = r_in.first_data;

    mnpr_ram #(
        .WIDTH($bits(mnpr_pkg::t_open)),
        .DEPTH(mnpr_pkg::NOTES)
    ) u_note_table (
        .i_clk  (i_clk),
        .i_we   (w_store),
        .i_waddr(w_key),
        .i_wdata(w_wr_entry),
        .i_re   (w_accept),
        .i_raddr(i_in.first_data),
        .o_rdata(w_rd_entry)
    );

    always_comb begin
        w_kind     = r_in.status_byte[6:4];
        w_repeat   = (r_in.event_time == r_last_time) &&
                     (r_in.status_byte == r_last_status) &&
                     (r_in.first_data == r_last_first) &&
                     (r_in.second_data == r_last_second);
        w_is_off   = (w_kind == mnpr_pkg::KIND_NOTE_OFF) ||
                     ((w_kind == mnpr_pkg::KIND_NOTE_ON) && (r_in.second_data == 7'd0));
        w_is_on    = (w_kind == mnpr_pkg::KIND_NOTE_ON) && (r_in.second_data != 7'd0);
        w_was_open = r_open_valid[w_key];
        w_full     = (r_count >= mnpr_pkg::CNT_W'(mnpr_pkg::MAX_RECORDS));

        w_do_close  = 1'b0;
        w_do_append = 1'b0;
        if (r_in.command == mnpr_pkg::CMD_EVENT && !w_repeat) begin
            if (w_is_off) begin
                w_do_close = w_was_open;
            end else if (w_is_on) begin
                w_do_close  = w_was_open;
                w_do_append = 1'b1;
            end else if (w_kind == mnpr_pkg::KIND_CTRL &&
                         (r_in.first_data == mnpr_pkg::CTRL_BANK_MSB ||
                          r_in.first_data == mnpr_pkg::CTRL_BANK_LSB)) begin
                w_do_append = 1'b0;
            end else if (w_kind == mnpr_pkg::KIND_PROGRAM) begin
                w_do_append = 1'b0;
            end else begin
                w_do_append = 1'b1;
            end
        end

        // The drum bank shifts stored notes up an octave.
        w_note = {1'b0, r_in.first_data};
        if (w_is_on && r_bank_high == mnpr_pkg::DRUM_BANK_MSB &&
            r_bank_low == mnpr_pkg::DRUM_BANK_LSB) begin
            w_note = {1'b0, r_in.first_data} + mnpr_pkg::DRUM_SHIFT;
        end

        w_close                = '0;
        w_close.action         = mnpr_pkg::ACT_LENGTH;
        w_close.record_index   = w_rd_entry.record;
        w_close.note_length    = r_in.event_time - w_rd_entry.start;
        w_close.last           = !w_do_append;

        w_append                = '0;
        w_append.action         = mnpr_pkg::ACT_APPEND;
        w_append.record_index   = w_full ? '0 : mnpr_pkg::INDEX_W'(r_count);
        w_append.record_time    = r_in.event_time;
        w_append.event_kind     = w_kind;
        w_append.note_value     = w_note;
        w_append.velocity_value = r_in.second_data;
        w_append.overflow       = w_full;
        w_append.last           = 1'b1;

        w_push.count  = {1'b0, w_do_close} + {1'b0, w_do_append};
        w_push.first  = w_do_close ? w_close : w_append;
        w_push.second = w_append;

        w_go = (w_push.count <= w_space);
        if (!(r_state == S_EXEC && w_go)) begin
            w_push.count = 2'd0;
        end

        w_store           = (r_state == S_EXEC) && w_go && w_is_on && w_do_append && !w_full;
        w_wr_entry.record = mnpr_pkg::INDEX_W'(r_count);
        w_wr_entry.start  = r_in.event_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_open_valid  <= '0;
            r_count       <= '0;
            r_last_time   <= '0;
            r_last_status <= '0;
            r_last_first  <= '0;
            r_last_second <= '0;
            r_bank_high   <= '0;
            r_bank_low    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_in.command == mnpr_pkg::CMD_BEGIN_TRACK) begin
                        r_state       <= S_IDLE;
                        r_open_valid  <= '0;
                        r_count       <= '0;
                        r_last_time   <= '0;
                        r_last_status <= '0;
                        r_last_first  <= '0;
                        r_last_second <= '0;
                        r_bank_high   <= '0;
                        r_bank_low    <= '0;
                    end else if (w_repeat) begin
                        r_state <= S_IDLE;
                    end else if (w_go) begin
                        r_state       <= S_IDLE;
                        r_last_time   <= r_in.event_time;
                        r_last_status <= r_in.status_byte;
                        r_last_first  <= r_in.first_data;
                        // A note-on over an open note records its closing note-off.
                        r_last_second <= (w_is_on && w_was_open) ? 7'd0 : r_in.second_data;
                        // A stored note-on reopens the key even when it also closed it.
                        if (w_is_on && w_do_append && !w_full) begin
                            r_open_valid[w_key] <= 1'b1;
                        end else if (w_do_close) begin
                            r_open_valid[w_key] <= 1'b0;
                        end
                        if (w_do_append && !w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (w_kind == mnpr_pkg::KIND_CTRL &&
                            r_in.first_data == mnpr_pkg::CTRL_BANK_MSB) begin
                            r_bank_high <= r_in.second_data;
                        end
                        if (w_kind == mnpr_pkg::KIND_CTRL &&
                            r_in.first_data == mnpr_pkg::CTRL_BANK_LSB) begin
                            r_bank_low <= r_in.second_data;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_in <= i_in;
        end
    end

    mnpr_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space    (w_space),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[verif/midi_note_pairing_recorder_tb.sv]
// Testbench for midi_note_pairing_recorder: a directed table of MIDI events
// followed by random note traffic with idle gaps on both sides.
// Depends on mnpr_pkg and the recorder RTL; every result is checked in order.
`timescale 1ns / 100ps

module midi_note_pairing_recorder_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_EVENTS  = 975;
    localparam int REPORT_LIMIT   = 30;

    // Event kinds the package does not name.
    localparam logic [2:0] KIND_KEY_PRESSURE  = 3'd2;
    localparam logic [2:0] KIND_CHAN_PRESSURE = 3'd5;
    localparam logic [2:0] KIND_PITCH_BEND    = 3'd6;
    localparam logic [2:0] KIND_SYSTEM        = 3'd7;
    localparam logic [6:0] CTRL_VOLUME        = 7'd7;

    localparam mnpr_pkg::t_out NO_RESULT = '0;

    typedef struct {
        mnpr_pkg::t_in  ev;
        int             n_typed;  // -1: results come from the predictor
        mnpr_pkg::t_out typed0;
        mnpr_pkg::t_out typed1;
    } t_row;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    mnpr_pkg::t_in  in_event  = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    mnpr_pkg::t_out out_record;

    midi_note_pairing_recorder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_event),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_record)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic                       note_open [mnpr_pkg::NOTES];
    logic [15:0]                note_record [mnpr_pkg::NOTES];
    logic [31:0]                note_start [mnpr_pkg::NOTES];
    logic [mnpr_pkg::CNT_W-1:0] record_fill;
    logic [31:0]                prev_time;
    logic [7:0]                 prev_status;
    logic [6:0]                 prev_first;
    logic [6:0]                 prev_second;
    logic [6:0]                 bank_msb;
    logic [6:0]                 bank_lsb;

    mnpr_pkg::t_out predicted [2];
    mnpr_pkg::t_out pending_records [$];
    t_row           script [$];

    int   mismatches        = 0;
    int   results_checked   = 0;
    int   events_sent       = 0;
    int   clears_sent       = 0;
    int   overflow_expected = 0;
    int   idle_cycles       = 0;
    bit   steady            = 1'b0;
    logic [31:0]   event_clock = 32'd100;
    mnpr_pkg::t_in last_random = '0;

    function automatic void clear_track();
        for (int k = 0; k < mnpr_pkg::NOTES; k++) begin
            note_open[k]   = 1'b0;
            note_record[k] = '0;
            note_start[k]  = '0;
        end
        record_fill = '0;
        prev_time   = '0;
        prev_status = '0;
        prev_first  = '0;
        prev_second = '0;
        bank_msb    = '0;
        bank_lsb    = '0;
    endfunction

    function automatic mnpr_pkg::t_out appended(logic [15:0] idx, logic [31:0] t,
                                                logic [2:0] kind, logic [7:0] note,
                                                logic [6:0] vel, bit lst);
        mnpr_pkg::t_out rec;
        rec                = '0;
        rec.action         = mnpr_pkg::ACT_APPEND;
        rec.record_index   = idx;
        rec.record_time    = t;
        rec.event_kind     = kind;
        rec.note_value     = note;
        rec.velocity_value = vel;
        rec.last           = lst;
        return rec;
    endfunction

    function automatic mnpr_pkg::t_out lengthened(logic [15:0] idx, logic [31:0] len,
                                                  bit lst);
        mnpr_pkg::t_out rec;
        rec              = '0;
        rec.action       = mnpr_pkg::ACT_LENGTH;
        rec.record_index = idx;
        rec.note_length  = len;
        rec.last         = lst;
        return rec;
    endfunction

    function automatic mnpr_pkg::t_out append_record(logic [31:0] t, logic [2:0] kind,
                                                     logic [7:0] note, logic [6:0] vel);
        mnpr_pkg::t_out rec;
        if (record_fill >= mnpr_pkg::MAX_RECORDS) begin
            rec = appended('0, t, kind, note, vel, 1'b0);
            rec.overflow = 1'b1;
        end else begin
            rec = appended(record_fill[15:0], t, kind, note, vel, 1'b0);
            record_fill++;
        end
        return rec;
    endfunction

    function automatic mnpr_pkg::t_out close_note(logic [6:0] key, logic [31:0] t);
        mnpr_pkg::t_out rec;
        rec = lengthened(note_record[key], t - note_start[key], 1'b0);
        note_open[key] = 1'b0;
        return rec;
    endfunction

    // Fills predicted[] with the results of one event and returns their number.
    function automatic int predict_event(mnpr_pkg::t_in ev);
        int          n;
        logic [2:0]  kind;
        logic [6:0]  key;
        logic [7:0]  note;
        logic [15:0] idx;
        n    = 0;
        kind = ev.status_byte[6:4];
        key  = ev.first_data;
        if (ev.command == mnpr_pkg::CMD_BEGIN_TRACK) begin
            clear_track();
            return 0;
        end
        if (ev.event_time == prev_time && ev.status_byte == prev_status &&
            ev.first_data == prev_first && ev.second_data == prev_second)
            return 0;
        prev_time   = ev.event_time;
        prev_status = ev.status_byte;
        prev_first  = ev.first_data;
        prev_second = ev.second_data;

        if (kind == mnpr_pkg::KIND_NOTE_OFF ||
            (kind == mnpr_pkg::KIND_NOTE_ON && ev.second_data == 0)) begin
            if (note_open[key]) begin
                predicted[n] = close_note(key, ev.event_time);
                n++;
            end
        end else if (kind == mnpr_pkg::KIND_NOTE_ON) begin
            note = {1'b0, key};
            if (bank_msb == mnpr_pkg::DRUM_BANK_MSB && bank_lsb == mnpr_pkg::DRUM_BANK_LSB)
                note = note + mnpr_pkg::DRUM_SHIFT;
            if (note_open[key]) begin
                // The implied note-off now counts as the previous event.
                prev_second  = '0;
                predicted[n] = close_note(key, ev.event_time);
                n++;
            end
            idx = record_fill[15:0];
            predicted[n] = append_record(ev.event_time, kind, note, ev.second_data);
            if (!predicted[n].overflow) begin
                note_open[key]   = 1'b1;
                note_record[key] = idx;
                note_start[key]  = ev.event_time;
            end
            n++;
        end else if (kind == mnpr_pkg::KIND_CTRL && key == mnpr_pkg::CTRL_BANK_MSB) begin
            bank_msb = ev.second_data;
        end else if (kind == mnpr_pkg::KIND_CTRL && key == mnpr_pkg::CTRL_BANK_LSB) begin
            bank_lsb = ev.second_data;
        end else if (kind != mnpr_pkg::KIND_PROGRAM) begin
            predicted[n] = append_record(ev.event_time, kind, {1'b0, key}, ev.second_data);
            n++;
        end
        if (n > 0)
            predicted[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic mnpr_pkg::t_in chan_event(logic [31:0] t, logic [2:0] kind,
                                                 logic [3:0] chan, logic [6:0] d0,
                                                 logic [6:0] d1);
        mnpr_pkg::t_in ev;
        ev.command     = mnpr_pkg::CMD_EVENT;
        ev.event_time  = t;
        ev.status_byte = {1'b1, kind, chan};
        ev.first_data  = d0;
        ev.second_data = d1;
        return ev;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly a small pool of keys so that notes overlap and get closed.
    function automatic logic [6:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return 7'(60 + $urandom_range(0, 7));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic mnpr_pkg::t_in random_event(bit allow_clear);
        mnpr_pkg::t_in ev;
        int            r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0)
            event_clock = $urandom();
        else
            event_clock = event_clock + $urandom_range(0, 3);
        ev.command     = mnpr_pkg::CMD_EVENT;
        ev.event_time  = event_clock;
        ev.status_byte = 8'($urandom_range(0, 255));
        ev.first_data  = pick_key();
        ev.second_data = 7'($urandom_range(1, 127));
        if (r < 32) begin
            ev.status_byte[6:4] = mnpr_pkg::KIND_NOTE_ON;
        end else if (r < 60) begin
            if ($urandom_range(0, 1)) begin
                ev.status_byte[6:4] = mnpr_pkg::KIND_NOTE_OFF;
                ev.second_data      = 7'($urandom_range(0, 127));
            end else begin
                ev.status_byte[6:4] = mnpr_pkg::KIND_NOTE_ON;
                ev.second_data      = '0;
            end
        end else if (r < 66 && last_random.command == mnpr_pkg::CMD_EVENT) begin
            ev = last_random;
        end else if (r < 74) begin
            ev.status_byte[6:4] = mnpr_pkg::KIND_CTRL;
            if ($urandom_range(0, 1)) begin
                ev.first_data  = mnpr_pkg::CTRL_BANK_MSB;
                ev.second_data = $urandom_range(0, 1) ? mnpr_pkg::DRUM_BANK_MSB
                                                      : 7'($urandom_range(0, 127));
            end else begin
                ev.first_data  = mnpr_pkg::CTRL_BANK_LSB;
                ev.second_data = $urandom_range(0, 1) ? mnpr_pkg::DRUM_BANK_LSB
                                                      : 7'($urandom_range(0, 127));
            end
        end else if (r < 78) begin
            ev.status_byte[6:4] = mnpr_pkg::KIND_PROGRAM;
        end else if (r < 80 && allow_clear) begin
            ev         = mnpr_pkg::t_in'({$urandom(), $urandom()});
            ev.command = mnpr_pkg::CMD_BEGIN_TRACK;
        end else begin
            ev.first_data  = 7'($urandom_range(0, 127));
            ev.second_data = 7'($urandom_range(0, 127));
        end
        last_random = ev;
        return ev;
    endfunction

    task automatic add_row(mnpr_pkg::t_in ev, int n_typed, mnpr_pkg::t_out typed0,
                           mnpr_pkg::t_out typed1);
        t_row row;
        row.ev      = ev;
        row.n_typed = n_typed;
        row.typed0  = typed0;
        row.typed1  = typed1;
        script.push_back(row);
    endtask

    // Holds the event until it is transferred, then queues what it should cause.
    task automatic send_event(mnpr_pkg::t_in ev, int n_typed, mnpr_pkg::t_out typed0,
                              mnpr_pkg::t_out typed1);
        int gap;
        int n;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_event <= ev;
        do @(posedge clk); while (!in_ready);
        n = predict_event(ev);
        if (n_typed >= 0) begin
            n            = n_typed;
            predicted[0] = typed0;
            predicted[1] = typed1;
        end
        for (int k = 0; k < n; k++) begin
            pending_records.push_back(predicted[k]);
            if (predicted[k].overflow)
                overflow_expected++;
        end
        events_sent++;
        if (ev.command == mnpr_pkg::CMD_BEGIN_TRACK)
            clears_sent++;
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_checked, name, got, want));
    endtask

    task automatic check_record(mnpr_pkg::t_out got);
        mnpr_pkg::t_out want;
        results_checked++;
        if (pending_records.size() == 0) begin
            report_mismatch($sformatf("result %0d %h arrived with nothing pending",
                                      results_checked, got));
            return;
        end
        want = pending_records.pop_front();
        compare_field("action", 32'(got.action), 32'(want.action));
        compare_field("record_index", 32'(got.record_index), 32'(want.record_index));
        compare_field("record_time", got.record_time, want.record_time);
        compare_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
        compare_field("note_value", 32'(got.note_value), 32'(want.note_value));
        compare_field("velocity_value", 32'(got.velocity_value),
                      32'(want.velocity_value));
        compare_field("note_length", got.note_length, want.note_length);
        compare_field("overflow", 32'(got.overflow), 32'(want.overflow));
        compare_field("last", 32'(got.last), 32'(want.last));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_record(out_record);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending_records.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: ready in bursts, with stalls drawn like the sender's gaps.
    initial begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial begin
        mnpr_pkg::t_in ev;
        clear_track();

        add_row('0, 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(5, mnpr_pkg::KIND_NOTE_ON, 0, 60, 100), 1,
                appended(0, 5, mnpr_pkg::KIND_NOTE_ON, 60, 100, 1), NO_RESULT);
        add_row(chan_event(5, mnpr_pkg::KIND_NOTE_ON, 0, 60, 100), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(12, mnpr_pkg::KIND_NOTE_OFF, 0, 60, 64), 1,
                lengthened(0, 7, 1), NO_RESULT);
        add_row(chan_event(13, mnpr_pkg::KIND_NOTE_OFF, 15, 60, 0), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(20, mnpr_pkg::KIND_NOTE_ON, 15, 0, 127), 1,
                appended(1, 20, mnpr_pkg::KIND_NOTE_ON, 0, 127, 1), NO_RESULT);
        // Retriggering an open key closes the old note before the new append.
        add_row(chan_event(30, mnpr_pkg::KIND_NOTE_ON, 0, 0, 1), 2,
                lengthened(1, 10, 0), appended(2, 30, mnpr_pkg::KIND_NOTE_ON, 0, 1, 1));
        // The implied note-off was the previous event, so this one is a repeat.
        add_row(chan_event(30, mnpr_pkg::KIND_NOTE_ON, 0, 0, 0), 0, NO_RESULT, NO_RESULT);
        ev = chan_event(31, mnpr_pkg::KIND_NOTE_ON, 0, 0, 0);
        ev.status_byte[7] = 1'b0;
        add_row(ev, 1, lengthened(2, 1, 1), NO_RESULT);
        add_row(chan_event(40, mnpr_pkg::KIND_CTRL, 0, mnpr_pkg::CTRL_BANK_MSB,
                           mnpr_pkg::DRUM_BANK_MSB), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(41, mnpr_pkg::KIND_CTRL, 0, mnpr_pkg::CTRL_BANK_LSB,
                           mnpr_pkg::DRUM_BANK_LSB), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(42, mnpr_pkg::KIND_NOTE_ON, 9, 127, 127), 1,
                appended(3, 42, mnpr_pkg::KIND_NOTE_ON, 139, 127, 1), NO_RESULT);
        add_row(chan_event(43, KIND_KEY_PRESSURE, 5, 127, 127), 1,
                appended(4, 43, KIND_KEY_PRESSURE, 127, 127, 1), NO_RESULT);
        add_row(chan_event(44, mnpr_pkg::KIND_PROGRAM, 0, 5, 0), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(45, mnpr_pkg::KIND_CTRL, 3, CTRL_VOLUME, 100), -1,
                NO_RESULT, NO_RESULT);
        add_row(chan_event(46, KIND_CHAN_PRESSURE, 0, 1, 2), -1, NO_RESULT, NO_RESULT);
        add_row(chan_event(47, KIND_PITCH_BEND, 0, 0, 0), -1, NO_RESULT, NO_RESULT);
        add_row(chan_event(48, KIND_SYSTEM, 0, 127, 0), 1,
                appended(8, 48, KIND_SYSTEM, 127, 0, 1), NO_RESULT);
        add_row(chan_event(32'hFFFF_FFF0, mnpr_pkg::KIND_NOTE_OFF, 0, 127, 127), 1,
                lengthened(3, 32'hFFFF_FFC6, 1), NO_RESULT);
        add_row(chan_event(32'hFFFF_FFF8, mnpr_pkg::KIND_NOTE_ON, 0, 64, 50), 1,
                appended(9, 32'hFFFF_FFF8, mnpr_pkg::KIND_NOTE_ON, 76, 50, 1), NO_RESULT);
        // The length wraps around the 32-bit time.
        add_row(chan_event(8, mnpr_pkg::KIND_NOTE_OFF, 0, 64, 0), 1,
                lengthened(9, 32'h10, 1), NO_RESULT);
        add_row(chan_event(9, mnpr_pkg::KIND_NOTE_ON, 0, 100, 1), 1,
                appended(10, 9, mnpr_pkg::KIND_NOTE_ON, 112, 1, 1), NO_RESULT);
        add_row(chan_event(10, mnpr_pkg::KIND_CTRL, 0, mnpr_pkg::CTRL_BANK_MSB, 0), 0,
                NO_RESULT, NO_RESULT);
        add_row('1, 0, NO_RESULT, NO_RESULT);
        // Key 100 was open before the new track; the clear must have closed it.
        add_row(chan_event(11, mnpr_pkg::KIND_NOTE_OFF, 0, 100, 0), 0, NO_RESULT, NO_RESULT);
        add_row(chan_event(12, mnpr_pkg::KIND_NOTE_ON, 0, 1, 2), 1,
                appended(0, 12, mnpr_pkg::KIND_NOTE_ON, 1, 2, 1), NO_RESULT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_event(script[i].ev, script[i].n_typed, script[i].typed0, script[i].typed1);

        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            steady = (i % 250) >= 200;
            send_event(random_event(1'b1), -1, NO_RESULT, NO_RESULT);
        end
        in_valid <= 1'b0;

        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d events (%0d track clears), checked %0d results,",
                 events_sent, clears_sent, results_checked);
        $display("including %0d appends refused by a full store.", overflow_expected);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
